FILE: rtl/svpwm_pkg.sv
package svpwm_pkg;

	localparam int CHANNEL_COUNT = 4;
	localparam int COUNTER_WIDTH = 16;
	localparam int HIP_CHANNELS  = 2;

	localparam int KIND_W    = 3;
	localparam int CH_W      = 2;
	localparam int ANGLE_W   = 12;
	localparam int WIDTH_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SET_ANGLE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SET_PULSE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_START     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DISABLE   = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TOP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MID  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HIP_LOW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIP_HIGH   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_KNEE_LOW   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_KNEE_HIGH  = 3'd7;

	localparam logic [COUNTER_WIDTH-1:0] RST_PERIOD_TOP = 16'd19999;
	localparam logic [WIDTH_W-1:0] RST_PULSE_MIN = 16'd1000;
	localparam logic [WIDTH_W-1:0] RST_PULSE_MID = 16'd1500;
	localparam logic [WIDTH_W-1:0] RST_PULSE_MAX = 16'd2000;
	localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT     = 12'sd1440;
	localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT_NEG = -12'sd1440;

	// width offset = floor(a * 500 / 1440) = floor(a * 25 / 72)
	// |a| * 25 / 72 = ((|a| * 25) >> 3) / 9, and / 9 is a reciprocal multiply
	localparam int MAG_W       = 16;
	localparam int DIV_SHIFT   = 3;
	localparam int QUOT_IN_W   = MAG_W - DIV_SHIFT;
	localparam int RECIP_SHIFT = 16;
	localparam int PROD_W      = 2 * QUOT_IN_W;
	localparam int Q_W         = PROD_W - RECIP_SHIFT;
	localparam int SUM_W       = WIDTH_W + 2;
	localparam logic [4:0] ANGLE_GAIN = 5'd25;
	localparam logic [6:0] NEG_BIAS   = 7'd71;
	localparam logic [QUOT_IN_W-1:0] RECIP_9 = 13'd7282;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} svpwm_ang_t;

	typedef struct packed {
		logic              fire;
		logic [KIND_W-1:0] kind;
		logic [CH_W-1:0]   channel;
		logic [WIDTH_W-1:0] width;
	} svpwm_cmd_t;

	typedef struct packed {
		logic [CHANNEL_COUNT-1:0] lines;
		logic                     cycle_start;
		logic                     outputs_on;
	} svpwm_stat_t;

endpackage

FILE: rtl/svpwm_angle_scale.sv
module svpwm_angle_scale
	import svpwm_pkg::*;
(
	input  logic [CH_W-1:0]           channel,
	input  logic signed [ANGLE_W-1:0] angle,
	input  logic signed [ANGLE_W-1:0] hip_low,
	input  logic signed [ANGLE_W-1:0] hip_high,
	input  logic signed [ANGLE_W-1:0] knee_low,
	input  logic signed [ANGLE_W-1:0] knee_high,
	output svpwm_ang_t                scaled
);

	logic signed [ANGLE_W-1:0] lo, hi, a_hi, a_lim, a_top, a_fin, a_neg;
	logic [ANGLE_W-2:0] mag;
	logic [MAG_W-1:0] prod;

	always_comb begin
		lo    = (32'(channel) < HIP_CHANNELS) ? hip_low : knee_low;
		hi    = (32'(channel) < HIP_CHANNELS) ? hip_high : knee_high;
		a_hi  = (angle > hi) ? hi : angle;
		a_lim = (a_hi < lo) ? lo : a_hi;
		a_top = (a_lim > ANGLE_LIMIT) ? ANGLE_LIMIT : a_lim;
		a_fin = (a_top < ANGLE_LIMIT_NEG) ? ANGLE_LIMIT_NEG : a_top;
		a_neg = -a_fin;
		mag   = a_fin[ANGLE_W-1] ? a_neg[ANGLE_W-2:0] : a_fin[ANGLE_W-2:0];
		prod  = MAG_W'(mag) * MAG_W'(ANGLE_GAIN);
		// floor of a negative quotient: round the magnitude up
		scaled.neg = a_fin[ANGLE_W-1];
		scaled.mag = prod + (a_fin[ANGLE_W-1] ? MAG_W'(NEG_BIAS) : '0);
	end

endmodule

FILE: rtl/svpwm_width_calc.sv
module svpwm_width_calc
	import svpwm_pkg::*;
(
	input  logic [KIND_W-1:0]  kind,
	input  svpwm_ang_t         scaled,
	input  logic [WIDTH_W-1:0] pulse_request,
	input  logic [WIDTH_W-1:0] pulse_min,
	input  logic [WIDTH_W-1:0] pulse_mid,
	input  logic [WIDTH_W-1:0] pulse_max,
	output logic [WIDTH_W-1:0] width
);

	logic [QUOT_IN_W-1:0] div_in;
	logic [PROD_W-1:0] prod;
	logic [Q_W-1:0] quot;
	logic signed [SUM_W-1:0] q_s, delta, sum, cand, min_s, max_s, c_hi, c_lo;

	always_comb begin
		div_in = QUOT_IN_W'(scaled.mag >> DIV_SHIFT);
		prod   = PROD_W'(div_in) * PROD_W'(RECIP_9);
		quot   = Q_W'(prod >> RECIP_SHIFT);
		q_s    = signed'(SUM_W'(quot));
		delta  = scaled.neg ? -q_s : q_s;
		sum    = signed'(SUM_W'(pulse_mid)) + delta;
		cand   = (kind == KIND_SET_ANGLE) ? sum : signed'(SUM_W'(pulse_request));
		min_s  = signed'(SUM_W'(pulse_min));
		max_s  = signed'(SUM_W'(pulse_max));
		c_hi   = (cand > max_s) ? max_s : cand;
		c_lo   = (c_hi < min_s) ? min_s : c_hi;
		width  = c_lo[WIDTH_W-1:0];
	end

endmodule

FILE: rtl/svpwm_timer.sv
module svpwm_timer
	import svpwm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  svpwm_cmd_t               cmd,
	input  logic [COUNTER_WIDTH-1:0] period_top,
	input  logic [WIDTH_W-1:0]       pulse_mid,
	output svpwm_stat_t              stat
);

	logic [COUNTER_WIDTH-1:0] count_q, count_n;
	logic [WIDTH_W-1:0] pending_q [CHANNEL_COUNT];
	logic [WIDTH_W-1:0] active_q  [CHANNEL_COUNT];
	logic [WIDTH_W-1:0] pending_n [CHANNEL_COUNT];
	logic [WIDTH_W-1:0] active_n  [CHANNEL_COUNT];
	logic en_q, en_n, wrap, cycle;

	always_comb begin
		count_n = count_q;
		en_n    = en_q;
		cycle   = 1'b0;
		for (int c = 0; c < CHANNEL_COUNT; c++) begin
			pending_n[c] = pending_q[c];
			active_n[c]  = active_q[c];
		end
		// a count at or past the top (top lowered) or at all ones wraps too
		wrap = (count_q >= period_top) || (count_q == '1);
		case (cmd.kind)
			KIND_TICK: begin
				if (wrap) begin
					count_n = '0;
					cycle   = 1'b1;
					for (int c = 0; c < CHANNEL_COUNT; c++)
						active_n[c] = pending_q[c];
				end else begin
					count_n = count_q + 1'b1;
				end
			end
			KIND_SET_ANGLE, KIND_SET_PULSE: begin
				if (32'(cmd.channel) < CHANNEL_COUNT)
					pending_n[cmd.channel] = cmd.width;
			end
			KIND_START: begin
				count_n = '0;
				en_n    = 1'b1;
				for (int c = 0; c < CHANNEL_COUNT; c++) begin
					pending_n[c] = pulse_mid;
					active_n[c]  = pulse_mid;
				end
			end
			KIND_DISABLE: en_n = 1'b0;
			default: ;
		endcase
		for (int c = 0; c < CHANNEL_COUNT; c++)
			stat.lines[c] = en_n && (WIDTH_W'(count_n) < active_n[c]);
		stat.cycle_start = cycle;
		stat.outputs_on  = en_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			en_q    <= 1'b0;
			for (int c = 0; c < CHANNEL_COUNT; c++) begin
				pending_q[c] <= RST_PULSE_MID;
				active_q[c]  <= RST_PULSE_MID;
			end
		end else if (cmd.fire) begin
			count_q <= count_n;
			en_q    <= en_n;
			for (int c = 0; c < CHANNEL_COUNT; c++) begin
				pending_q[c] <= pending_n[c];
				active_q[c]  <= active_n[c];
			end
		end
	end

endmodule

FILE: rtl/four_channel_servo_pwm_core.sv
// Four-channel servo PWM core. Each tick item advances the period counter by one or wraps it
// to zero; set angle and set pulse items load a channel's pending width, which takes effect at
// the next wrap. One item is accepted per clock while s_tready is high. An item is registered
// on entry (limit clamp and angle scaling in front of that register), then the width
// divide-by-reciprocal, the clamp and the counter and compare update run in one pass into the
// output register. s_tready falls only while both the input and output registers hold items
// because m_tready is low. Write configuration only while no item is in flight.
module four_channel_servo_pwm_core
	import svpwm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,  // channel[1:0], angle[13:2], pulse_request[29:14]
	input  logic [KIND_W-1:0]    s_tuser,  // kind[2:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,  // pwm_lines[3:0], cycle_start[4],
	                                       // applied_pulse[20:5], outputs_on[21]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [COUNTER_WIDTH-1:0] period_top_q;
	logic [WIDTH_W-1:0] pulse_min_q, pulse_mid_q, pulse_max_q;
	logic signed [ANGLE_W-1:0] hip_low_q, hip_high_q, knee_low_q, knee_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_top_q <= RST_PERIOD_TOP;
			pulse_min_q  <= RST_PULSE_MIN;
			pulse_mid_q  <= RST_PULSE_MID;
			pulse_max_q  <= RST_PULSE_MAX;
			hip_low_q    <= ANGLE_LIMIT_NEG;
			hip_high_q   <= ANGLE_LIMIT;
			knee_low_q   <= ANGLE_LIMIT_NEG;
			knee_high_q  <= ANGLE_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PERIOD_TOP: period_top_q <= cfg_wdata[COUNTER_WIDTH-1:0];
				REG_PULSE_MIN:  pulse_min_q  <= cfg_wdata[WIDTH_W-1:0];
				REG_PULSE_MID:  pulse_mid_q  <= cfg_wdata[WIDTH_W-1:0];
				REG_PULSE_MAX:  pulse_max_q  <= cfg_wdata[WIDTH_W-1:0];
				REG_HIP_LOW:    hip_low_q    <= signed'(cfg_wdata[ANGLE_W-1:0]);
				REG_HIP_HIGH:   hip_high_q   <= signed'(cfg_wdata[ANGLE_W-1:0]);
				REG_KNEE_LOW:   knee_low_q   <= signed'(cfg_wdata[ANGLE_W-1:0]);
				REG_KNEE_HIGH:  knee_high_q  <= signed'(cfg_wdata[ANGLE_W-1:0]);
				default: ;
			endcase
		end
	end

	// input stage
	logic [CH_W-1:0] in_channel;
	logic signed [ANGLE_W-1:0] in_angle;
	logic [WIDTH_W-1:0] in_request;
	svpwm_ang_t in_scaled;

	assign in_channel = s_tdata[1:0];
	assign in_angle   = signed'(s_tdata[13:2]);
	assign in_request = s_tdata[29:14];

	svpwm_angle_scale u_angle (
		.channel   (in_channel),
		.angle     (in_angle),
		.hip_low   (hip_low_q),
		.hip_high  (hip_high_q),
		.knee_low  (knee_low_q),
		.knee_high (knee_high_q),
		.scaled    (in_scaled)
	);

	logic valid_s1, advance;
	logic [KIND_W-1:0] kind_s1;
	logic [CH_W-1:0] channel_s1;
	logic [WIDTH_W-1:0] request_s1;
	svpwm_ang_t scaled_s1;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1    <= s_tuser;
			channel_s1 <= in_channel;
			request_s1 <= in_request;
			scaled_s1  <= in_scaled;
		end
	end

	// width, state update and result
	logic [WIDTH_W-1:0] width;
	logic applies;
	svpwm_cmd_t cmd;
	svpwm_stat_t stat;

	svpwm_width_calc u_width (
		.kind          (kind_s1),
		.scaled        (scaled_s1),
		.pulse_request (request_s1),
		.pulse_min     (pulse_min_q),
		.pulse_mid     (pulse_mid_q),
		.pulse_max     (pulse_max_q),
		.width         (width)
	);

	assign applies = ((kind_s1 == KIND_SET_ANGLE) || (kind_s1 == KIND_SET_PULSE))
		&& (32'(channel_s1) < CHANNEL_COUNT);

	assign cmd.fire    = advance;
	assign cmd.kind    = kind_s1;
	assign cmd.channel = channel_s1;
	assign cmd.width   = width;

	svpwm_timer u_timer (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.period_top (period_top_q),
		.pulse_mid  (pulse_mid_q),
		.stat       (stat)
	);

	logic out_valid_q;
	logic [CHANNEL_COUNT-1:0] lines_q;
	logic cycle_q, on_q;
	logic [WIDTH_W-1:0] applied_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lines_q   <= stat.lines;
			cycle_q   <= stat.cycle_start;
			on_q      <= stat.outputs_on;
			applied_q <= applies ? width : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, on_q, applied_q, cycle_q, lines_q};

	// lines stay low whenever the outputs are off
	a_off_lines_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !on_q |-> lines_q == '0)
		else $error("pwm lines high while outputs off");

	// an item stalled in the input stage keeps its contents
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(kind_s1) && $stable(channel_s1)
			&& $stable(request_s1))
		else $error("input stage changed while stalled");

	// an empty output register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with empty output register");

	// wrap is reported only for ticks
	a_cycle_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		advance && stat.cycle_start |-> kind_s1 == KIND_TICK)
		else $error("cycle start on a non-tick item");

endmodule

FILE: tb/servo_pwm_checker.sv
`timescale 1ns / 100ps

module servo_pwm_checker
	import svpwm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [31:0]          s_tdata,  // channel[1:0], angle[13:2], pulse_request[29:14]
	input  logic [KIND_W-1:0]    s_tuser,  // kind[2:0]
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [23:0]          m_tdata,  // pwm_lines[3:0], cycle_start[4],
	                                       // applied_pulse[20:5], outputs_on[21]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output int                   fail_count,
	output int                   pending_count
);

	localparam longint FULL_SWING_STEPS = 1440;  // 90 degrees in sixteenths
	localparam longint HALF_SPAN_TICKS  = 500;

	typedef struct packed {
		logic [CHANNEL_COUNT-1:0] lines;
		logic                     cycle_start;
		logic [WIDTH_W-1:0]       applied;
		logic                     outputs_on;
	} servo_result_t;

	servo_result_t pwm_result_q[$];
	servo_result_t want;
	int            mismatch_n = 0;

	// configuration copy
	logic [COUNTER_WIDTH-1:0]   period_top_r;
	logic [WIDTH_W-1:0]         pulse_min_r, pulse_mid_r, pulse_max_r;
	logic signed [ANGLE_W-1:0]  hip_lo_r, hip_hi_r, knee_lo_r, knee_hi_r;

	// servo state copy
	logic [COUNTER_WIDTH-1:0]   tick_cnt;
	logic [WIDTH_W-1:0]         pending_w [CHANNEL_COUNT];
	logic [WIDTH_W-1:0]         active_w [CHANNEL_COUNT];
	logic                       lines_enabled;

	function automatic longint clamp_range(longint v, longint lo, longint hi);
		// low wins when the limits cross
		if (v > hi)
			v = hi;
		if (v < lo)
			v = lo;
		return v;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_v);
		if (mismatch_n < 50)
			$display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, exp_v);
		mismatch_n++;
	endtask

	task automatic predict_servo_result(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch,
	                                    input logic signed [ANGLE_W-1:0] ang,
	                                    input logic [WIDTH_W-1:0] req);
		servo_result_t r;
		longint        a, num, q;
		logic [WIDTH_W-1:0] w;
		r = '0;
		case (kind)
			KIND_TICK: begin
				if (tick_cnt >= period_top_r || tick_cnt == '1) begin
					tick_cnt = '0;
					for (int c = 0; c < CHANNEL_COUNT; c++)
						active_w[c] = pending_w[c];
					r.cycle_start = 1'b1;
				end else begin
					tick_cnt = tick_cnt + 1'b1;
				end
			end
			KIND_SET_ANGLE: begin
				if (ch < HIP_CHANNELS)
					a = clamp_range(ang, hip_lo_r, hip_hi_r);
				else
					a = clamp_range(ang, knee_lo_r, knee_hi_r);
				a = clamp_range(a, ANGLE_LIMIT_NEG, ANGLE_LIMIT);
				num = pulse_mid_r;
				num = num * FULL_SWING_STEPS + a * HALF_SPAN_TICKS;
				q = num / FULL_SWING_STEPS;
				// round toward minus infinity
				if (num % FULL_SWING_STEPS != 0 && num < 0)
					q = q - 1;
				w = WIDTH_W'(clamp_range(q, pulse_min_r, pulse_max_r));
				pending_w[ch] = w;
				r.applied = w;
			end
			KIND_SET_PULSE: begin
				w = WIDTH_W'(clamp_range(req, pulse_min_r, pulse_max_r));
				pending_w[ch] = w;
				r.applied = w;
			end
			KIND_START: begin
				for (int c = 0; c < CHANNEL_COUNT; c++) begin
					pending_w[c] = pulse_mid_r;
					active_w[c] = pulse_mid_r;
				end
				tick_cnt = '0;
				lines_enabled = 1'b1;
			end
			KIND_DISABLE: lines_enabled = 1'b0;
			default: ;
		endcase
		if (lines_enabled) begin
			for (int c = 0; c < CHANNEL_COUNT; c++)
				r.lines[c] = (tick_cnt < active_w[c]);
		end
		r.outputs_on = lines_enabled;
		pwm_result_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_top_r = RST_PERIOD_TOP;
			pulse_min_r = RST_PULSE_MIN;
			pulse_mid_r = RST_PULSE_MID;
			pulse_max_r = RST_PULSE_MAX;
			hip_lo_r = ANGLE_LIMIT_NEG;
			hip_hi_r = ANGLE_LIMIT;
			knee_lo_r = ANGLE_LIMIT_NEG;
			knee_hi_r = ANGLE_LIMIT;
			tick_cnt = '0;
			for (int c = 0; c < CHANNEL_COUNT; c++) begin
				pending_w[c] = RST_PULSE_MID;
				active_w[c] = RST_PULSE_MID;
			end
			lines_enabled = 1'b0;
			pwm_result_q.delete();
			pending_count <= 0;
			fail_count <= mismatch_n;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PERIOD_TOP: period_top_r = cfg_wdata;
					REG_PULSE_MIN:  pulse_min_r = cfg_wdata;
					REG_PULSE_MID:  pulse_mid_r = cfg_wdata;
					REG_PULSE_MAX:  pulse_max_r = cfg_wdata;
					REG_HIP_LOW:    hip_lo_r = cfg_wdata[ANGLE_W-1:0];
					REG_HIP_HIGH:   hip_hi_r = cfg_wdata[ANGLE_W-1:0];
					REG_KNEE_LOW:   knee_lo_r = cfg_wdata[ANGLE_W-1:0];
					REG_KNEE_HIGH:  knee_hi_r = cfg_wdata[ANGLE_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (pwm_result_q.size() == 0) begin
					report_mismatch("unrequested item", m_tdata, 0);
				end else begin
					want = pwm_result_q.pop_front();
					if (m_tdata[3:0] !== want.lines)
						report_mismatch("pwm_lines", m_tdata[3:0], want.lines);
					if (m_tdata[4] !== want.cycle_start)
						report_mismatch("cycle_start", m_tdata[4], want.cycle_start);
					if (m_tdata[20:5] !== want.applied)
						report_mismatch("applied_pulse", m_tdata[20:5], want.applied);
					if (m_tdata[21] !== want.outputs_on)
						report_mismatch("outputs_on", m_tdata[21], want.outputs_on);
				end
			end
			if (s_tvalid && s_tready)
				predict_servo_result(s_tuser, s_tdata[1:0], s_tdata[13:2], s_tdata[29:14]);
			pending_count <= pwm_result_q.size();
			fail_count <= mismatch_n;
		end
	end

endmodule

FILE: tb/tb_four_channel_servo_pwm_core.sv
`timescale 1ns / 100ps

module tb_four_channel_servo_pwm_core;
	import svpwm_pkg::*;

	localparam int RANDOM_PHASES    = 6;
	localparam int ITEMS_PER_PHASE  = 145;
	localparam int PRESSURE_ITEMS   = 40;
	localparam int HOLD_OFF_CYCLES  = 200;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [31:0]          s_tdata;  // channel[1:0], angle[13:2], pulse_request[29:14]
	logic [KIND_W-1:0]    s_tuser;  // kind[2:0]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [23:0]          m_tdata;  // pwm_lines[3:0], cycle_start[4],
	                                // applied_pulse[20:5], outputs_on[21]
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	int                   fail_count;
	int                   pending_count;

	logic [CFG_W-1:0] cfg_plan [8];
	bit               tx_idle = 1'b1;
	bit               rx_idle = 1'b1;
	bit               rx_hold = 1'b0;

	four_channel_servo_pwm_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	servo_pwm_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

	// result side: ready bursts, idle bursts and one long hold-off on request
	initial begin
		int hold_cycles;
		forever begin
			if (rx_hold) begin
				rx_hold = 1'b0;
				m_tready <= 1'b0;
				for (hold_cycles = 0; hold_cycles < HOLD_OFF_CYCLES; hold_cycles++)
					@(posedge clk);
			end else if (rx_idle && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch,
	                         input logic [ANGLE_W-1:0] ang, input logic [WIDTH_W-1:0] req);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {2'b00, req, ang, ch};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_tick();
		send_item(KIND_TICK, CH_W'($urandom), ANGLE_W'($urandom), WIDTH_W'($urandom));
	endtask

	task automatic send_random_item();
		int                  pick;
		logic [KIND_W-1:0]   kind;
		logic [ANGLE_W-1:0]  ang;
		logic [WIDTH_W-1:0]  req;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			kind = KIND_TICK;
		else if (pick < 72)
			kind = KIND_SET_ANGLE;
		else if (pick < 88)
			kind = KIND_SET_PULSE;
		else if (pick < 93)
			kind = KIND_START;
		else if (pick < 97)
			kind = KIND_DISABLE;
		else
			kind = KIND_W'($urandom_range(5, 7));
		case ($urandom_range(0, 2))
			0: ang = ANGLE_W'($urandom);
			1: begin
				// near the plus or minus 90 degree edge
				ang = ANGLE_W'($urandom_range(1360, 1520));
				if ($urandom_range(0, 1) == 1)
					ang = -ang;
			end
			default: ang = ANGLE_W'($urandom_range(0, 200)) - ANGLE_W'(100);
		endcase
		case ($urandom_range(0, 3))
			0: req = WIDTH_W'($urandom);
			1: req = WIDTH_W'($urandom_range(0, 100));
			2: req = cfg_plan[REG_PULSE_MIN] + WIDTH_W'($urandom_range(0, 4)) - WIDTH_W'(2);
			default: req = cfg_plan[REG_PULSE_MAX] + WIDTH_W'($urandom_range(0, 4)) - WIDTH_W'(2);
		endcase
		send_item(kind, CH_W'($urandom), ang, req);
	endtask

	task automatic randomize_cfg();
		cfg_plan[REG_PERIOD_TOP] = CFG_W'($urandom_range(1, 64));
		cfg_plan[REG_PULSE_MIN]  = CFG_W'($urandom_range(0, 30));
		cfg_plan[REG_PULSE_MID]  = CFG_W'($urandom_range(0, 60));
		cfg_plan[REG_PULSE_MAX]  = CFG_W'($urandom_range(20, 90));
		cfg_plan[REG_HIP_LOW]    = CFG_W'($urandom_range(0, 2880)) - CFG_W'(1440);
		cfg_plan[REG_HIP_HIGH]   = CFG_W'($urandom_range(0, 2880)) - CFG_W'(1440);
		cfg_plan[REG_KNEE_LOW]   = CFG_W'($urandom_range(0, 2880)) - CFG_W'(1440);
		cfg_plan[REG_KNEE_HIGH]  = CFG_W'($urandom_range(0, 2880)) - CFG_W'(1440);
	endtask

	// drain the block, then write all registers from the plan
	task automatic apply_cfg();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_wdata <= cfg_plan[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= KIND_TICK;
		cfg_we <= 1'b0;
		cfg_index <= REG_PERIOD_TOP;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, outputs still off
		send_tick();
		send_tick();
		send_item(KIND_SET_ANGLE, 2'd0, 12'h7FF, 16'h0000);
		send_item(KIND_SET_ANGLE, 2'd1, 12'h800, 16'hFFFF);
		send_item(KIND_SET_ANGLE, 2'd2, 12'h000, 16'h0000);
		send_item(KIND_SET_ANGLE, 2'd3, 12'hFFF, 16'hFFFF);
		send_item(KIND_SET_PULSE, 2'd0, 12'hFFF, 16'h0000);
		send_item(KIND_SET_PULSE, 2'd3, 12'h000, 16'hFFFF);
		send_item(KIND_SET_PULSE, 2'd1, 12'h555, 16'd1234);
		send_item(KIND_START, 2'd0, 12'h000, 16'h0000);
		send_tick();
		send_tick();
		send_item(KIND_SET_PULSE, 2'd2, 12'hAAA, 16'd1700);
		send_tick();
		send_item(KIND_DISABLE, 2'd3, 12'h000, 16'h0000);
		send_tick();
		send_item(KIND_W'(5), 2'd1, 12'h123, 16'h4321);
		send_item(KIND_W'(6), 2'd2, 12'h456, 16'h8765);
		send_item(KIND_W'(7), 2'd3, 12'h789, 16'hCBA9);
		send_item(KIND_START, 2'd0, 12'h000, 16'h0000);
		send_tick();

		// crossed hip limits, zero minimum, full-scale maximum, short period
		cfg_plan[REG_PERIOD_TOP] = 16'd3;
		cfg_plan[REG_PULSE_MIN]  = 16'd0;
		cfg_plan[REG_PULSE_MID]  = 16'd0;
		cfg_plan[REG_PULSE_MAX]  = 16'hFFFF;
		cfg_plan[REG_HIP_LOW]    = 16'd100;
		cfg_plan[REG_HIP_HIGH]   = -16'sd100;
		cfg_plan[REG_KNEE_LOW]   = -16'sd1440;
		cfg_plan[REG_KNEE_HIGH]  = 16'd1440;
		apply_cfg();
		send_item(KIND_START, 2'd0, 12'h000, 16'h0000);
		send_item(KIND_SET_ANGLE, 2'd0, 12'h7FF, 16'h0000);
		send_item(KIND_SET_ANGLE, 2'd2, 12'h800, 16'h0000);
		send_item(KIND_SET_PULSE, 2'd1, 12'h000, 16'hFFFF);
		repeat (6) send_tick();

		// zero period: every tick wraps
		cfg_plan[REG_PERIOD_TOP] = 16'd0;
		apply_cfg();
		repeat (4) send_tick();

		// full-range period: let the counter run past the periods chosen below
		cfg_plan[REG_PERIOD_TOP] = 16'hFFFF;
		cfg_plan[REG_PULSE_MIN]  = RST_PULSE_MIN;
		cfg_plan[REG_PULSE_MID]  = RST_PULSE_MID;
		cfg_plan[REG_PULSE_MAX]  = RST_PULSE_MAX;
		cfg_plan[REG_HIP_LOW]    = -16'sd1440;
		cfg_plan[REG_HIP_HIGH]   = 16'd1440;
		apply_cfg();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_item(KIND_START, 2'd0, 12'h000, 16'h0000);
		repeat (100) send_tick();
		tx_idle = 1'b1;
		rx_idle = 1'b1;

		// the count now sits above every period chosen below
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 2) begin
				cfg_plan[REG_PERIOD_TOP] = 16'd1;
				cfg_plan[REG_PULSE_MIN]  = 16'hFFFF;
				cfg_plan[REG_PULSE_MID]  = 16'hFFFF;
				cfg_plan[REG_PULSE_MAX]  = 16'd0;
				cfg_plan[REG_HIP_LOW]    = -16'sd1440;
				cfg_plan[REG_HIP_HIGH]   = 16'd1440;
				cfg_plan[REG_KNEE_LOW]   = 16'd1440;
				cfg_plan[REG_KNEE_HIGH]  = -16'sd1440;
			end else begin
				randomize_cfg();
			end
			if (p == RANDOM_PHASES - 1) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			apply_cfg();
			send_item(KIND_START, CH_W'($urandom), ANGLE_W'($urandom), WIDTH_W'($urandom));
			if (p == 1) begin
				// back-to-back items against a stalled receiver
				tx_idle = 1'b0;
				rx_hold = 1'b1;
				repeat (PRESSURE_ITEMS) send_random_item();
				tx_idle = 1'b1;
			end
			repeat (ITEMS_PER_PHASE) send_random_item();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
